// ===== rtl/dhcp_option_filter_inject_assert.svh =====
`ifndef DHCP_OPTION_FILTER_INJECT_ASSERT_SVH
`define DHCP_OPTION_FILTER_INJECT_ASSERT_SVH

// same-cycle implication
`define DOFI_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dofi assertion failed");

// next-cycle implication
`define DOFI_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dofi assertion failed");

`endif

// ===== rtl/dofi_pkg.sv =====
package dofi_pkg;

    localparam int MAX_CODES    = 8;
    localparam int INJECT_BYTES = 32;
    localparam int MIN_PAYLOAD  = 300;
    localparam int HDR_BYTES    = 240;
    localparam int MIN_OPT      = MIN_PAYLOAD - HDR_BYTES;

    localparam logic HDR_PARITY = 1'(HDR_BYTES % 2);

    localparam logic [7:0] OPT_PAD = 8'h00;
    localparam logic [7:0] OPT_END = 8'hFF;

    localparam int COUNT_W = 11;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam int PAD_W   = 9;
    localparam int INJ_IDX_W = 5;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;
    localparam logic [QCNT_W-1:0] QFULL = QCNT_W'(QDEPTH);

    localparam logic [1:0] POL_DROP = 2'd0;
    localparam logic [1:0] POL_KEEP = 2'd1;

    localparam logic [2:0] REG_EXISTING_POLICY = 3'd0;
    localparam logic [2:0] REG_MATCH_COUNT     = 3'd1;
    localparam logic [2:0] REG_MATCH_CODES     = 3'd2;
    localparam logic [2:0] REG_INJECT_LEN      = 3'd3;
    localparam logic [2:0] REG_INJECT_WORD_0   = 3'd4;
    localparam logic [2:0] REG_INJECT_WORD_1   = 3'd5;
    localparam logic [2:0] REG_INJECT_WORD_2   = 3'd6;
    localparam logic [2:0] REG_INJECT_WORD_3   = 3'd7;

    typedef struct packed {
        logic [1:0]       existing_policy;
        logic [3:0]       match_count;
        logic [63:0]      match_codes;
        logic [5:0]       inject_len;
        logic [3:0][63:0] inject_word;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       tail;
        logic       drop;
    } qent_t;

endpackage

// ===== rtl/dhcp_option_filter_inject.sv =====
// DHCP options region rewriter: parses option records one byte per transfer, filters
// options whose code matches the configured list (keep, remove, or drop the packet), and
// on END or the last byte emits the injection bytes, END, and PAD bytes up to the
// minimum BOOTP size and an even length. Passed-through bytes flow at one per cycle when
// neither the output nor the queue stalls; the tail burst goes out one byte per cycle
// from the back-end sequencer while m_ready allows, and a four-entry queue keeps the parser
// taking input until it fills. Configuration registers sit at byte address 8*i on the
// 64-bit port and must be written only while the block is idle.
module dhcp_option_filter_inject (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_option_byte,
    input  logic        s_packet_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_kind,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    dofi_pkg::cfg_t  cfg_reg;
    dofi_pkg::qent_t push_ent;
    dofi_pkg::qent_t head;
    logic            push;
    logic            q_ready;
    logic            head_v;
    logic            pop;
    logic            wr_en;
    logic [2:0]      reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                dofi_pkg::REG_EXISTING_POLICY: cfg_reg.existing_policy <= pwdata[1:0];
                dofi_pkg::REG_MATCH_COUNT:     cfg_reg.match_count     <= pwdata[3:0];
                dofi_pkg::REG_MATCH_CODES:     cfg_reg.match_codes     <= pwdata;
                dofi_pkg::REG_INJECT_LEN:      cfg_reg.inject_len      <= pwdata[5:0];
                dofi_pkg::REG_INJECT_WORD_0:   cfg_reg.inject_word[0]  <= pwdata;
                dofi_pkg::REG_INJECT_WORD_1:   cfg_reg.inject_word[1]  <= pwdata;
                dofi_pkg::REG_INJECT_WORD_2:   cfg_reg.inject_word[2]  <= pwdata;
                dofi_pkg::REG_INJECT_WORD_3:   cfg_reg.inject_word[3]  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dofi_pkg::REG_EXISTING_POLICY: prdata = {62'd0, cfg_reg.existing_policy};
            dofi_pkg::REG_MATCH_COUNT:     prdata = {60'd0, cfg_reg.match_count};
            dofi_pkg::REG_MATCH_CODES:     prdata = cfg_reg.match_codes;
            dofi_pkg::REG_INJECT_LEN:      prdata = {58'd0, cfg_reg.inject_len};
            dofi_pkg::REG_INJECT_WORD_0:   prdata = cfg_reg.inject_word[0];
            dofi_pkg::REG_INJECT_WORD_1:   prdata = cfg_reg.inject_word[1];
            dofi_pkg::REG_INJECT_WORD_2:   prdata = cfg_reg.inject_word[2];
            dofi_pkg::REG_INJECT_WORD_3:   prdata = cfg_reg.inject_word[3];
            default:                       prdata = '0;
        endcase
    end

    dofi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_option_byte (s_option_byte),
        .s_packet_end  (s_packet_end),
        .q_ready       (q_ready),
        .push          (push),
        .push_ent      (push_ent)
    );

    dofi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_ent (push_ent),
        .q_ready  (q_ready),
        .head_v   (head_v),
        .head     (head),
        .pop      (pop)
    );

    dofi_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_v     (head_v),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

endmodule

// ===== rtl/dofi_front.sv =====
module dofi_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  dofi_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_option_byte,
    input  logic              s_packet_end,
    input  logic              q_ready,
    output logic              push,
    output dofi_pkg::qent_t   push_ent
);

    typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_DATA, PH_DISCARD} phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  rem_reg, rem_next;
    logic        copy_reg, copy_next;
    logic        accept;
    logic        hit;
    logic        matched;
    logic        drop;
    logic [3:0]  cnt;
    dofi_pkg::qent_t ent;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cnt = (cfg.match_count > 4'(dofi_pkg::MAX_CODES)) ? 4'(dofi_pkg::MAX_CODES)
                                                          : cfg.match_count;
        hit = 1'b0;
        for (int i = 0; i < dofi_pkg::MAX_CODES; i++) begin
            if (4'(i) < cnt && cfg.match_codes[8*i +: 8] == s_option_byte) begin
                hit = 1'b1;
            end
        end
        matched = (cfg.existing_policy != dofi_pkg::POL_KEEP) && hit;
        drop    = matched && (cfg.existing_policy == dofi_pkg::POL_DROP);
    end

    always_comb begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        copy_next    = copy_reg;
        ent          = '0;
        ent.data     = s_option_byte;
        case (phase_reg)
            PH_CODE: begin
                if (s_option_byte == dofi_pkg::OPT_END) begin
                    ent.tail   = 1'b1;
                    phase_next = s_packet_end ? PH_CODE : PH_DISCARD;
                end else if (drop) begin
                    ent.drop   = 1'b1;
                    ent.data   = '0;
                    phase_next = s_packet_end ? PH_CODE : PH_DISCARD;
                end else begin
                    copy_next    = !matched;
                    ent.has_byte = !matched;
                    ent.tail     = s_packet_end;
                    if (s_packet_end || s_option_byte == dofi_pkg::OPT_PAD) begin
                        phase_next = PH_CODE;
                    end else begin
                        phase_next = PH_LEN;
                    end
                end
            end
            PH_LEN: begin
                ent.has_byte = copy_reg;
                ent.tail     = s_packet_end;
                rem_next     = s_option_byte;
                if (s_packet_end || s_option_byte == 8'd0) begin
                    phase_next = PH_CODE;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                ent.has_byte = copy_reg;
                ent.tail     = s_packet_end;
                rem_next     = rem_reg - 8'd1;
                if (s_packet_end || rem_reg == 8'd1) begin
                    phase_next = PH_CODE;
                end
            end
            PH_DISCARD: begin
                if (s_packet_end) begin
                    phase_next = PH_CODE;
                end
            end
            default: begin
                phase_next = PH_CODE;
            end
        endcase
    end

    assign push     = accept && (ent.has_byte || ent.tail || ent.drop);
    assign push_ent = ent;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CODE;
            rem_reg   <= '0;
            copy_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            copy_reg  <= copy_next;
        end
    end

endmodule

// ===== rtl/dofi_queue.sv =====
`include "dhcp_option_filter_inject_assert.svh"

module dofi_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  dofi_pkg::qent_t push_ent,
    output logic            q_ready,
    output logic            head_v,
    output dofi_pkg::qent_t head,
    input  logic            pop
);

    dofi_pkg::qent_t                 mem_reg [dofi_pkg::QDEPTH];
    logic [dofi_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [dofi_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign q_ready = (count_reg != dofi_pkg::QFULL);
    assign head_v  = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `DOFI_ASSERT_IMPL(a_no_push_full, aclk, aresetn, push, count_reg != dofi_pkg::QFULL)
    `DOFI_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0)

endmodule

// ===== rtl/dofi_back.sv =====
`include "dhcp_option_filter_inject_assert.svh"

module dofi_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  dofi_pkg::cfg_t  cfg,
    input  logic            head_v,
    input  dofi_pkg::qent_t head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_kind,
    output logic            m_last
);

    typedef enum logic [1:0] {B_HEAD, B_INJ, B_END, B_PAD} bstate_t;

    bstate_t                          state_reg, state_next;
    logic                             byte_done_reg, byte_done_next;
    logic [dofi_pkg::INJ_IDX_W-1:0]   idx_reg, idx_next;
    logic [dofi_pkg::PAD_W-1:0]       pad_reg, pad_next;
    logic [dofi_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic                             parity_reg, parity_next;
    logic                             m_valid_reg, m_valid_next;
    logic [7:0]                       m_out_byte_reg, m_out_byte_next;
    logic                             m_kind_reg, m_kind_next;
    logic                             m_last_reg, m_last_next;

    logic                             adv;
    logic                             do_inj;
    logic                             do_end;
    logic                             finish;
    logic [5:0]                       inj_len;
    logic [dofi_pkg::INJ_IDX_W-1:0]   cur_idx;
    logic [dofi_pkg::COUNT_W-1:0]     count_inc;
    logic [dofi_pkg::COUNT_W-1:0]     pad_full;
    logic [dofi_pkg::PAD_W-1:0]       pad_val;
    logic [31:0][7:0]                 inj_bytes;

    assign inj_bytes  = cfg.inject_word;
    assign inj_len    = (cfg.inject_len > 6'(dofi_pkg::INJECT_BYTES))
                        ? 6'(dofi_pkg::INJECT_BYTES) : cfg.inject_len;
    assign adv        = !m_valid_reg || m_ready;
    assign cur_idx    = (state_reg == B_INJ) ? idx_reg : '0;
    assign count_inc  = (count_reg == dofi_pkg::COUNT_MAX) ? count_reg
                                                           : count_reg + 1'b1;
    assign pad_full   = dofi_pkg::COUNT_W'(dofi_pkg::MIN_OPT) - count_inc;
    assign pad_val    = (count_inc < dofi_pkg::COUNT_W'(dofi_pkg::MIN_OPT))
                        ? pad_full[dofi_pkg::PAD_W-1:0]
                        : {{(dofi_pkg::PAD_W-1){1'b0}}, (~parity_reg) ^ dofi_pkg::HDR_PARITY};

    always_comb begin
        state_next      = state_reg;
        byte_done_next  = byte_done_reg;
        idx_next        = idx_reg;
        pad_next        = pad_reg;
        count_next      = count_reg;
        parity_next     = parity_reg;
        m_valid_next    = m_valid_reg;
        m_out_byte_next = m_out_byte_reg;
        m_kind_next     = m_kind_reg;
        m_last_next     = m_last_reg;
        pop             = 1'b0;
        do_inj          = 1'b0;
        do_end          = 1'b0;
        finish          = 1'b0;
        if (adv) begin
            m_valid_next = 1'b0;
            case (state_reg)
                B_HEAD: begin
                    if (head_v) begin
                        if (head.drop) begin
                            m_valid_next    = 1'b1;
                            m_out_byte_next = '0;
                            m_kind_next     = 1'b1;
                            m_last_next     = 1'b1;
                            finish          = 1'b1;
                        end else if (head.has_byte && !byte_done_reg) begin
                            m_valid_next    = 1'b1;
                            m_out_byte_next = head.data;
                            m_kind_next     = 1'b0;
                            m_last_next     = 1'b0;
                            count_next      = count_inc;
                            parity_next     = ~parity_reg;
                            if (head.tail) begin
                                byte_done_next = 1'b1;
                            end else begin
                                pop = 1'b1;
                            end
                        end else if (inj_len != '0) begin
                            do_inj = 1'b1;
                        end else begin
                            do_end = 1'b1;
                        end
                    end
                end
                B_INJ: begin
                    do_inj = 1'b1;
                end
                B_END: begin
                    do_end = 1'b1;
                end
                B_PAD: begin
                    m_valid_next    = 1'b1;
                    m_out_byte_next = dofi_pkg::OPT_PAD;
                    m_kind_next     = 1'b0;
                    m_last_next     = (pad_reg == dofi_pkg::PAD_W'(1));
                    pad_next        = pad_reg - 1'b1;
                    finish          = (pad_reg == dofi_pkg::PAD_W'(1));
                end
                default: begin
                    state_next = B_HEAD;
                end
            endcase
            if (do_inj) begin
                m_valid_next    = 1'b1;
                m_out_byte_next = inj_bytes[cur_idx];
                m_kind_next     = 1'b0;
                m_last_next     = 1'b0;
                count_next      = count_inc;
                parity_next     = ~parity_reg;
                idx_next        = cur_idx + 1'b1;
                if ({1'b0, cur_idx} + 6'd1 == inj_len) begin
                    state_next = B_END;
                end else begin
                    state_next = B_INJ;
                end
            end
            if (do_end) begin
                m_valid_next    = 1'b1;
                m_out_byte_next = dofi_pkg::OPT_END;
                m_kind_next     = 1'b0;
                m_last_next     = (pad_val == '0);
                count_next      = count_inc;
                parity_next     = ~parity_reg;
                pad_next        = pad_val;
                if (pad_val == '0) begin
                    finish = 1'b1;
                end else begin
                    state_next = B_PAD;
                end
            end
            if (finish) begin
                pop            = 1'b1;
                state_next     = B_HEAD;
                byte_done_next = 1'b0;
                count_next     = '0;
                parity_next    = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_HEAD;
            byte_done_reg  <= 1'b0;
            idx_reg        <= '0;
            pad_reg        <= '0;
            count_reg      <= '0;
            parity_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            m_out_byte_reg <= '0;
            m_kind_reg     <= 1'b0;
            m_last_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            byte_done_reg  <= byte_done_next;
            idx_reg        <= idx_next;
            pad_reg        <= pad_next;
            count_reg      <= count_next;
            parity_reg     <= parity_next;
            m_valid_reg    <= m_valid_next;
            m_out_byte_reg <= m_out_byte_next;
            m_kind_reg     <= m_kind_next;
            m_last_reg     <= m_last_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_kind     = m_kind_reg;
    assign m_last     = m_last_reg;

    // drop result closes the packet with a zero byte
    `DOFI_ASSERT_IMPL(a_drop_last, aclk, aresetn, m_valid_reg && m_kind_reg, m_last_reg && m_out_byte_reg == '0)
    `DOFI_ASSERT_IMPL(a_pad_nonzero, aclk, aresetn, state_reg == B_PAD, pad_reg != '0)
    // tail sequencing holds its queue entry until done
    `DOFI_ASSERT_IMPL(a_tail_head, aclk, aresetn, state_reg != B_HEAD, head_v && head.tail)

endmodule

// ===== tb/tb_dhcp_option_filter_inject.sv =====
`timescale 1ns / 100ps

module tb_dhcp_option_filter_inject;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int LONG_BYTES = 32;
    localparam int RANDOM_PHASES = 4;
    localparam logic [1:0] POL_REMOVE = 2'd2;
    localparam logic [1:0] POL_BOTH   = 2'd3;

    typedef enum logic [1:0] {WANT_CODE, WANT_LEN, IN_DATA, SKIP_REST} parse_ph_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       last;
    } res_t;

    typedef struct {
        int         preset;
        logic [7:0] b;
        logic       e;
        bit         typed;
        res_t       r;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_option_byte = 8'h00;
    logic        s_packet_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_kind;
    logic        m_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = 6'd0;
    logic [63:0] pwdata = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    dhcp_option_filter_inject dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_option_byte (s_option_byte),
        .s_packet_end  (s_packet_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_kind        (m_kind),
        .m_last        (m_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 aclk = ~aclk;

    // shadow of the configuration registers
    logic [1:0]  pol_r = 2'd0;
    logic [3:0]  mcount_r = 4'd0;
    logic [63:0] mcodes_r = 64'd0;
    logic [5:0]  ilen_r = 6'd0;
    logic [63:0] iword_r [4] = '{64'd0, 64'd0, 64'd0, 64'd0};

    // parser shadow state
    parse_ph_t   ph = WANT_CODE;
    logic [7:0]  remain = 8'd0;
    logic        copying = 1'b0;
    logic [10:0] emitted = 11'd0;
    logic        odd = 1'b0;

    res_t        step_res[$];
    res_t        expected_out[$];
    dir_row_t    dir_rows[$];
    logic [7:0]  pkt[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  cycle_count = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit listed(input logic [7:0] code);
        int n;
        n = (mcount_r > dofi_pkg::MAX_CODES) ? dofi_pkg::MAX_CODES : int'(mcount_r);
        for (int i = 0; i < n; i++) begin
            if (mcodes_r[8*i +: 8] == code) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic restart_packet();
        ph = WANT_CODE;
        remain = 8'd0;
        copying = 1'b0;
        emitted = 11'd0;
        odd = 1'b0;
    endtask

    task automatic emit(input logic [7:0] b, input logic k);
        res_t r;
        r.out_byte = b;
        r.kind = k;
        r.last = 1'b0;
        step_res.push_back(r);
        if (!k) begin
            if (emitted != dofi_pkg::COUNT_MAX) emitted = emitted + 11'd1;
            odd = ~odd;
        end
    endtask

    task automatic emit_tail();
        int n;
        int total;
        int pad;
        res_t r;
        n = (ilen_r > dofi_pkg::INJECT_BYTES) ? dofi_pkg::INJECT_BYTES : int'(ilen_r);
        for (int i = 0; i < n; i++) emit(iword_r[i/8][8*(i%8) +: 8], 1'b0);
        emit(dofi_pkg::OPT_END, 1'b0);
        total = dofi_pkg::HDR_BYTES + int'(emitted);
        if (total < dofi_pkg::MIN_PAYLOAD) pad = dofi_pkg::MIN_PAYLOAD - total;
        else pad = int'(dofi_pkg::HDR_PARITY ^ odd);
        for (int i = 0; i < pad; i++) emit(dofi_pkg::OPT_PAD, 1'b0);
        r = step_res.pop_back();
        r.last = 1'b1;
        step_res.push_back(r);
    endtask

    // rewritten bytes caused by one options byte, left in step_res
    task automatic rewrite_byte(input logic [7:0] b, input logic e);
        logic m;
        logic done;
        res_t r;
        step_res.delete();
        done = 1'b0;
        case (ph)
            WANT_CODE: begin
                if (b == dofi_pkg::OPT_END) begin
                    emit_tail();
                    done = 1'b1;
                end else begin
                    m = (pol_r != dofi_pkg::POL_KEEP) && listed(b);
                    if (m && pol_r == dofi_pkg::POL_DROP) begin
                        r.out_byte = 8'h00;
                        r.kind = 1'b1;
                        r.last = 1'b1;
                        step_res.push_back(r);
                        if (e) restart_packet();
                        else ph = SKIP_REST;
                        return;
                    end
                    copying = !m;
                    if (copying) emit(b, 1'b0);
                    ph = (b == dofi_pkg::OPT_PAD) ? WANT_CODE : WANT_LEN;
                end
            end
            WANT_LEN: begin
                if (copying) emit(b, 1'b0);
                remain = b;
                ph = (b != 8'd0) ? IN_DATA : WANT_CODE;
            end
            IN_DATA: begin
                if (copying) emit(b, 1'b0);
                remain = remain - 8'd1;
                if (remain == 8'd0) ph = WANT_CODE;
            end
            default: begin
                if (e) restart_packet();
                return;
            end
        endcase
        if (!done && e) begin
            emit_tail();
            done = 1'b1;
        end
        if (done) begin
            if (e) restart_packet();
            else ph = SKIP_REST;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic e, input bit use_typed,
                             input res_t typed);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        rewrite_byte(b, e);
        if (use_typed) expected_out.push_back(typed);
        else foreach (step_res[i]) expected_out.push_back(step_res[i]);
        s_valid <= 1'b1;
        s_option_byte <= b;
        s_packet_end <= e;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (idx)
            dofi_pkg::REG_EXISTING_POLICY: pol_r = val[1:0];
            dofi_pkg::REG_MATCH_COUNT:     mcount_r = val[3:0];
            dofi_pkg::REG_MATCH_CODES:     mcodes_r = val;
            dofi_pkg::REG_INJECT_LEN:      ilen_r = val[5:0];
            dofi_pkg::REG_INJECT_WORD_0:   iword_r[0] = val;
            dofi_pkg::REG_INJECT_WORD_1:   iword_r[1] = val;
            dofi_pkg::REG_INJECT_WORD_2:   iword_r[2] = val;
            dofi_pkg::REG_INJECT_WORD_3:   iword_r[3] = val;
            default: ;
        endcase
    endtask

    task automatic apply_preset(input int p);
        wait_drained();
        case (p)
            1: begin
                cfg_write(dofi_pkg::REG_EXISTING_POLICY, 64'(dofi_pkg::POL_DROP));
                cfg_write(dofi_pkg::REG_MATCH_COUNT, 64'd8);
                cfg_write(dofi_pkg::REG_MATCH_CODES, 64'hFE77_5133_2A0F_0603);
                cfg_write(dofi_pkg::REG_INJECT_LEN, 64'd32);
                cfg_write(dofi_pkg::REG_INJECT_WORD_0, 64'h0123_4567_89AB_CDEF);
                cfg_write(dofi_pkg::REG_INJECT_WORD_1, 64'hFEDC_BA98_7654_3210);
                cfg_write(dofi_pkg::REG_INJECT_WORD_2, 64'h00FF_00FF_00FF_00FF);
                cfg_write(dofi_pkg::REG_INJECT_WORD_3, 64'h8000_0000_0000_0001);
            end
            2: begin
                cfg_write(dofi_pkg::REG_EXISTING_POLICY, 64'(dofi_pkg::POL_KEEP));
                cfg_write(dofi_pkg::REG_MATCH_COUNT, 64'd15);
                cfg_write(dofi_pkg::REG_INJECT_LEN, 64'd63);
            end
            3: begin
                cfg_write(dofi_pkg::REG_EXISTING_POLICY, 64'(POL_REMOVE));
                cfg_write(dofi_pkg::REG_MATCH_COUNT, 64'd2);
                cfg_write(dofi_pkg::REG_MATCH_CODES, 64'h0000_0000_0000_3300);
                cfg_write(dofi_pkg::REG_INJECT_LEN, 64'd0);
            end
            4: begin
                cfg_write(dofi_pkg::REG_EXISTING_POLICY, 64'(POL_BOTH));
                cfg_write(dofi_pkg::REG_MATCH_COUNT, 64'd8);
                cfg_write(dofi_pkg::REG_MATCH_CODES, 64'hFFFF_FFFF_FFFF_33FF);
                cfg_write(dofi_pkg::REG_INJECT_LEN, 64'd5);
                cfg_write(dofi_pkg::REG_INJECT_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            default: ;
        endcase
    endtask

    task automatic random_config();
        wait_drained();
        cfg_write(dofi_pkg::REG_EXISTING_POLICY, {$urandom, $urandom});
        cfg_write(dofi_pkg::REG_MATCH_COUNT,
                  ($urandom_range(0, 1) == 0) ? 64'($urandom_range(1, 8))
                                              : 64'($urandom_range(0, 15)));
        cfg_write(dofi_pkg::REG_MATCH_CODES, {$urandom, $urandom});
        cfg_write(dofi_pkg::REG_INJECT_LEN, 64'($urandom_range(0, 63)));
        for (int i = 0; i < 4; i++) begin
            cfg_write(3'(dofi_pkg::REG_INJECT_WORD_0 + i), {$urandom, $urandom});
        end
    endtask

    task automatic add_row(input int preset, input logic [7:0] b, input logic e, input bit typed,
                           input logic [7:0] ob, input logic k, input logic l);
        dir_row_t row;
        row.preset = preset;
        row.b = b;
        row.e = e;
        row.typed = typed;
        row.r = {ob, k, l};
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] pick_code(input bit avoid);
        logic [7:0] c;
        int n;
        int r;
        n = (mcount_r > dofi_pkg::MAX_CODES) ? dofi_pkg::MAX_CODES : int'(mcount_r);
        r = $urandom_range(0, 99);
        if (!avoid && r < 15) return dofi_pkg::OPT_PAD;
        if (!avoid && r < 50 && n > 0) return mcodes_r[8*$urandom_range(0, n-1) +: 8];
        do c = 8'($urandom_range(1, 254)); while (avoid && listed(c));
        return c;
    endfunction

    task automatic add_option(input bit avoid, input int len_max);
        int len;
        pkt.push_back(pick_code(avoid));
        if (pkt[$] == dofi_pkg::OPT_PAD) return;
        len = $urandom_range(0, len_max);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom));
    endtask

    task automatic send_packet();
        res_t none;
        none = '0;
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, 1'b0, none);
    endtask

    task automatic random_packet();
        int style;
        int cut;
        pkt.delete();
        steady = ($urandom_range(0, 4) == 0);
        style = $urandom_range(0, 99);
        if (style < 10) begin
            repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 6)) add_option(1'b0, ($urandom_range(0, 9) == 0) ? 40 : 8);
            if (style < 22) begin
                cut = $urandom_range(1, pkt.size());
                while (pkt.size() > cut) void'(pkt.pop_back());
            end else if (style < 90) begin
                pkt.push_back(dofi_pkg::OPT_END);
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
                end
            end
        end
        send_packet();
    endtask

    // back-to-back packet offered while the result side holds off
    task automatic long_packet();
        pkt.delete();
        steady = 1'b1;
        while (pkt.size() < LONG_BYTES) add_option(1'b1, 12);
        pkt.push_back(dofi_pkg::OPT_END);
        s_valid <= 1'b0;
        hold_req = 1'b1;
        while (hold_req) @(posedge aclk);
        send_packet();
    endtask

    initial begin
        int start;
        restart_packet();
        // after reset: everything copied, empty injection
        add_row(0, 8'h35, 1'b0, 1'b1, 8'h35, 1'b0, 1'b0);
        add_row(0, 8'h01, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0);
        add_row(0, 8'h05, 1'b0, 1'b1, 8'h05, 1'b0, 1'b0);
        add_row(0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h12, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // drop on conflict, full injection
        add_row(1, 8'h0C, 1'b0, 1'b1, 8'h0C, 1'b0, 1'b0);
        add_row(0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h03, 1'b0, 1'b1, 8'h00, 1'b1, 1'b1);
        add_row(0, 8'h44, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h55, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // keep, oversized count and length, truncated option
        add_row(2, 8'h03, 1'b0, 1'b1, 8'h03, 1'b0, 1'b0);
        add_row(0, 8'h04, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'hAA, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'hBB, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // remove, PAD among the listed codes
        add_row(3, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h33, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h11, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h22, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'h01, 1'b0, 1'b1, 8'h01, 1'b0, 1'b0);
        add_row(0, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
        add_row(0, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
        // policy three acts as remove
        add_row(4, 8'h33, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].preset != 0) apply_preset(dir_rows[i].preset);
            send_byte(dir_rows[i].b, dir_rows[i].e, dir_rows[i].typed, dir_rows[i].r);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            random_config();
            start = items_sent;
            while (items_sent - start < 35) begin
                random_packet();
                if (phase == 1 && items_sent - start < 12) wait_drained();
            end
            if (phase == 3) long_packet();
        end

        wait_drained();
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // result side ready pattern, with one long hold-off on request
    initial begin
        int run;
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        res_t got;
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_out_byte, m_kind, m_last};
            if (expected_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected transfer: byte %02h kind %0d last %0d",
                             got.out_byte, got.kind, got.last);
                end
            end else begin
                want = expected_out.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp %02h/%0d/%0d got %02h/%0d/%0d",
                                 want.out_byte, want.kind, want.last,
                                 got.out_byte, got.kind, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
